// ----- src/dfpc_pkg.sv -----
// Shared types and constants for the deduplicating FIFO peer cache.
`timescale 1ns / 1ps

package dfpc_pkg;

  localparam int unsigned SlotsDefault = 256;
  localparam int unsigned CfgW = 9;
  localparam logic [CfgW-1:0] SlotsInUseReset = 9'd256;
  localparam int unsigned InDataW = 312;
  localparam int unsigned OutDataW = 24;
  localparam logic [31:0] Ipv4AllOnes = 32'hFFFF_FFFF;
  localparam logic [31:0] MappedTag = 32'h0000_FFFF;

  typedef enum logic [1:0] {
    STAT_NEW     = 2'd0,
    STAT_EVICT   = 2'd1,
    STAT_DUP     = 2'd2,
    STAT_INVALID = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic        valid;
    logic [63:0] id_high;
    logic [63:0] id_middle;
    logic [31:0] id_low;
    logic        is_ipv6;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic [15:0] port;
  } entry_t;

  typedef struct packed {
    logic [7:0] slot;
    logic [8:0] count;
    status_e    status;
  } result_t;

endpackage

// ----- src/dedup_fifo_peer_cache_core.sv -----
// Deduplicating FIFO peer cache: entry memory, linear duplicate scan and ring writer.
// A valid request runs SCAN, DRAIN, DECIDE, then DONE; an invalid one goes straight to DONE.
// The scan reads one entry per cycle; no new request is taken until the last leaves DONE.
// The output register lets the next request be accepted while a result waits to be taken.
// After reset a clearing pass zeroes the memory, accepting no request.
// Configuration writes are taken at any time, and slots_in_use resets to 256.
`timescale 1ns / 1ps

module dedup_fifo_peer_cache_core #(
  parameter int unsigned SLOTS = dfpc_pkg::SlotsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [dfpc_pkg::CfgW-1:0]     cfg_wdata_i,   // slots_in_use
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // node_id_high[63:0], node_id_middle[127:64], node_id_low[159:128], is_ipv6[160],
  // address_high[224:161], address_low[288:225], peer_port[304:289], zero fill above
  input  logic [dfpc_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // status[1:0], count_after[10:2], slot_written[18:11], zero fill above
  output logic [dfpc_pkg::OutDataW-1:0] m_axis_tdata
);
  import dfpc_pkg::*;

  localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned CmpW = (CW > CfgW) ? CW : CfgW;

  entry_t mem_q [SLOTS];

  state_e          state_q, state_d;
  logic [AW-1:0]   cnt_q, cnt_d;
  logic [AW-1:0]   ptr_q, ptr_d;
  logic [AW-1:0]   p_q, p_d;
  logic [CW-1:0]   count_q, count_d;
  logic [CfgW-1:0] cfg_q;
  entry_t          req_q, req_d;
  logic            hit_q, hit_d;
  logic            pvalid_q, pvalid_d;
  result_t         res_q, res_d;
  logic            out_valid_q, out_valid_d;
  result_t         out_q, out_d;

  logic            rd_vld_q, rd_en_c;
  logic [AW-1:0]   rd_idx_q;
  entry_t          rd_data_q;
  logic            we_c;
  logic [AW-1:0]   waddr_c;
  entry_t          wdata_c;

  logic [CmpW-1:0] cap_c;
  logic [CmpW-1:0] cfg_ext_c;
  logic [CmpW-1:0] p_next_c;
  entry_t          in_entry_c;
  logic            in_ok_c;
  logic            mapped_c;
  logic [31:0]     ip4_c;
  logic [63:0]     ah_c;
  logic [63:0]     al_c;
  logic            in_v6_c;
  logic [15:0]     in_port_c;

  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW - $bits(result_t)){1'b0}}, out_q};

  always_comb begin
    ah_c      = s_axis_tdata[224:161];
    al_c      = s_axis_tdata[288:225];
    in_v6_c   = s_axis_tdata[160];
    in_port_c = s_axis_tdata[304:289];
    ip4_c     = al_c[31:0];
    mapped_c  = (ah_c == 64'd0) && (al_c[63:32] == MappedTag);

    in_entry_c.valid     = 1'b1;
    in_entry_c.id_high   = s_axis_tdata[63:0];
    in_entry_c.id_middle = s_axis_tdata[127:64];
    in_entry_c.id_low    = s_axis_tdata[159:128];
    in_entry_c.port      = in_port_c;
    if (!in_v6_c || mapped_c) begin
      in_ok_c              = (ip4_c != 32'd0) && (ip4_c != Ipv4AllOnes);
      in_entry_c.is_ipv6   = 1'b0;
      in_entry_c.addr_high = 64'd0;
      in_entry_c.addr_low  = {32'd0, ip4_c};
    end else begin
      in_ok_c              = (ah_c | al_c) != 64'd0;
      in_entry_c.is_ipv6   = 1'b1;
      in_entry_c.addr_high = ah_c;
      in_entry_c.addr_low  = al_c;
    end
    if (in_port_c == 16'd0) begin
      in_ok_c = 1'b0;
    end
  end

  always_comb begin
    cfg_ext_c = CmpW'(cfg_q);
    if (cfg_ext_c == '0) begin
      cap_c = CmpW'(1);
    end else if (cfg_ext_c > CmpW'(SLOTS)) begin
      cap_c = CmpW'(SLOTS);
    end else begin
      cap_c = cfg_ext_c;
    end
    p_next_c = CmpW'(p_q) + CmpW'(1);
  end

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    ptr_d         = ptr_q;
    p_d           = p_q;
    count_d       = count_q;
    req_d         = req_q;
    hit_d         = hit_q;
    pvalid_d      = pvalid_q;
    res_d         = res_q;
    out_valid_d   = out_valid_q;
    out_d         = out_q;
    s_axis_tready = 1'b0;
    rd_en_c       = 1'b0;
    we_c          = 1'b0;
    waddr_c       = cnt_q;
    wdata_c       = '0;

    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    if (rd_vld_q) begin
      if (rd_data_q.valid && rd_data_q.id_high == req_q.id_high &&
          rd_data_q.id_middle == req_q.id_middle && rd_data_q.id_low == req_q.id_low) begin
        hit_d = 1'b1;
      end
      if (rd_idx_q == p_q) begin
        pvalid_d = rd_data_q.valid;
      end
    end

    case (state_q)
      ST_CLEAR: begin
        we_c  = 1'b1;
        cnt_d = cnt_q + AW'(1);
        if (cnt_q == AW'(SLOTS - 1)) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          req_d    = in_entry_c;
          hit_d    = 1'b0;
          pvalid_d = 1'b0;
          cnt_d    = '0;
          p_d      = (CmpW'(ptr_q) >= cap_c) ? '0 : ptr_q;
          if (in_ok_c) begin
            state_d = ST_SCAN;
          end else begin
            res_d.status = STAT_INVALID;
            res_d.count  = 9'(count_q);
            res_d.slot   = 8'd0;
            state_d      = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        rd_en_c = 1'b1;
        cnt_d   = cnt_q + AW'(1);
        if (cnt_q == AW'(SLOTS - 1)) begin
          cnt_d   = '0;
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (hit_q) begin
          res_d.status = STAT_DUP;
          res_d.count  = 9'(count_q);
          res_d.slot   = 8'd0;
        end else begin
          we_c    = 1'b1;
          waddr_c = p_q;
          wdata_c = req_q;
          ptr_d   = (p_next_c >= cap_c) ? '0 : AW'(p_next_c);
          if (pvalid_q) begin
            res_d.status = STAT_EVICT;
            res_d.count  = 9'(count_q);
          end else begin
            count_d      = count_q + CW'(1);
            res_d.status = STAT_NEW;
            res_d.count  = 9'(count_q + CW'(1));
          end
          res_d.slot = 8'(p_q);
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we_c) begin
      mem_q[waddr_c] <= wdata_c;
    end
    if (rd_en_c) begin
      rd_data_q <= mem_q[cnt_q];
    end
    rd_idx_q <= cnt_q;
    req_q    <= req_d;
    p_q      <= p_d;
    res_q    <= res_d;
    out_q    <= out_d;
    hit_q    <= hit_d;
    pvalid_q <= pvalid_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      ptr_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      rd_vld_q    <= 1'b0;
      cfg_q       <= SlotsInUseReset;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ptr_q       <= ptr_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      rd_vld_q    <= rd_en_c;
      if (cfg_valid_i) begin
        cfg_q <= cfg_wdata_i;
      end
    end
  end

endmodule
